FILE: hw/rtl/ordered_list_edit_engine_macros.svh
// ----------------------------------------------------------------------------
// ordered list edit engine assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_EDIT_ENGINE_MACROS_SVH
`define ORDERED_LIST_EDIT_ENGINE_MACROS_SVH

// same-cycle implication
`define OLEE_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("%m: property failed");

// next-cycle implication
`define OLEE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

FILE: hw/rtl/olee_pkg.sv
// ----------------------------------------------------------------------------
// olee_pkg
// types and codes shared by the ordered list edit engine
// ----------------------------------------------------------------------------
package olee_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 7;
  localparam int STATUS_W  = 3;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_KEY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_TL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_POS = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOKEY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_WRAP
  } cell_op_t;

  typedef enum logic [1:0] {
    EDIT_NONE,
    EDIT_INSERT,
    EDIT_REMOVE,
    EDIT_ROTATE
  } edit_kind_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_INS,
    FSM_READ
  } fsm_state_t;

endpackage

FILE: hw/rtl/ordered_list_edit_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_edit_engine
// ordered list of up to DEPTH signed values held in a chain of cells
// ----------------------------------------------------------------------------
// channel   ports                                   transfer
// input     start, busy, in_cmd/value/key/position  start high, busy low
// result    out_valid, out_status/element/count/last one cycle, out_valid high
//
// append, prepend and both deletes finish in the accept cycle; the result is
// registered and shows in the next cycle. insert after key rotates the list
// once through the chain in FSM_SCAN, then inserts in FSM_INS.
// read out rotates the list once, one result per cycle, count results.
// reset empties the list; results cannot be held off.
// ----------------------------------------------------------------------------
module ordered_list_edit_engine #(
  parameter int DEPTH = olee_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [olee_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [olee_pkg::DATA_W-1:0]   in_value,
  input  logic signed [olee_pkg::DATA_W-1:0]   in_key,
  input  logic [olee_pkg::POS_W-1:0]           in_position,
  output logic                                 out_valid,
  output logic [olee_pkg::STATUS_W-1:0]        out_status,
  output logic signed [olee_pkg::DATA_W-1:0]   out_element,
  output logic [olee_pkg::POS_W-1:0]           out_count,
  output logic                                 out_last
);
  import olee_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  fsm_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [IDX_W-1:0]   hit_r, hit_nxt;
  logic               found_r, found_nxt;
  logic [DATA_W-1:0]  value_r, value_nxt;
  logic [DATA_W-1:0]  key_r, key_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_element_r, out_element_nxt;
  logic [POS_W-1:0]    out_count_r;
  logic                out_last_r, out_last_nxt;

  edit_kind_t         edit_kind;
  logic [POS_W-1:0]   edit_at;
  logic [DATA_W-1:0]  edit_value;
  logic [POS_W-1:0]   cnt7;
  logic               full;
  logic               last_step;
  logic               match;
  logic [DATA_W-1:0]  head;

  cell_op_t           cell_op   [DEPTH];
  logic [DATA_W-1:0]  cell_data [DEPTH];

  assign cnt7      = POS_W'(count_r);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head      = cell_data[0];
  assign last_step = (CNT_W'(step_r) == count_r - CNT_W'(1));
  assign match     = (head == key_r);
  assign busy      = (state_r != FSM_IDLE);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    step_nxt        = step_r;
    hit_nxt         = hit_r;
    found_nxt       = found_r;
    value_nxt       = value_r;
    key_nxt         = key_r;
    edit_kind       = EDIT_NONE;
    edit_at         = '0;
    edit_value      = value_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = ST_OK;
    out_element_nxt = '0;
    out_last_nxt    = 1'b1;
    unique case (state_r)
      FSM_IDLE: begin
        edit_value = in_value;
        if (start) begin
          value_nxt = in_value;
          key_nxt   = in_key;
          step_nxt  = '0;
          found_nxt = 1'b0;
          unique case (in_cmd)
            CMD_APPEND, CMD_PREPEND: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                edit_kind = EDIT_INSERT;
                edit_at   = (in_cmd == CMD_APPEND) ? cnt7 : '0;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_INS_KEY: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = FSM_SCAN;
              end
            end
            CMD_DEL_TL: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_DEL_POS: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (in_position == '0 || in_position > cnt7) begin
                out_status_nxt = ST_BADPOS;
              end else begin
                edit_kind = EDIT_REMOVE;
                edit_at   = in_position - POS_W'(1);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_READ: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = FSM_READ;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        edit_kind = EDIT_ROTATE;
        if (!found_r && match) begin
          found_nxt = 1'b1;
          hit_nxt   = step_r;
        end
        if (last_step) begin
          if (!(found_r || match)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOKEY;
            state_nxt      = FSM_IDLE;
          end else if (full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            state_nxt      = FSM_IDLE;
          end else begin
            state_nxt = FSM_INS;
          end
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      FSM_INS: begin
        edit_kind     = EDIT_INSERT;
        edit_at       = POS_W'(hit_r) + POS_W'(1);
        count_nxt     = count_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = FSM_IDLE;
      end
      FSM_READ: begin
        edit_kind       = EDIT_ROTATE;
        out_valid_nxt   = 1'b1;
        out_element_nxt = head;
        out_last_nxt    = last_step;
        if (last_step) begin
          state_nxt = FSM_IDLE;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    hit_r         <= hit_nxt;
    value_r       <= value_nxt;
    key_r         <= key_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_count_r   <= POS_W'(count_nxt);
    out_last_r    <= out_last_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [POS_W-1:0] SLOT = POS_W'(i);
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = edit_value;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    always_comb begin
      cell_op[i] = CELL_HOLD;
      unique case (edit_kind)
        EDIT_INSERT: begin
          if (SLOT == edit_at) begin
            cell_op[i] = CELL_LOAD;
          end else if (SLOT > edit_at) begin
            cell_op[i] = CELL_LEFT;
          end
        end
        EDIT_REMOVE: begin
          if (SLOT >= edit_at) begin
            cell_op[i] = CELL_RIGHT;
          end
        end
        EDIT_ROTATE: begin
          if (SLOT == cnt7 - POS_W'(1)) begin
            cell_op[i] = CELL_WRAP;
          end else if (SLOT < cnt7) begin
            cell_op[i] = CELL_RIGHT;
          end
        end
        default: begin
          cell_op[i] = CELL_HOLD;
        end
      endcase
    end

    olee_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .load_data  (edit_value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (head),
      .data       (cell_data[i])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_count   = out_count_r;
  assign out_last    = out_last_r;

endmodule

FILE: hw/rtl/olee_cell.sv
// ----------------------------------------------------------------------------
// olee_cell
// one list slot: holds a value, loads one, or takes a neighbour's or the head's value
// ----------------------------------------------------------------------------
module olee_cell (
  input  logic                        clk,
  input  olee_pkg::cell_op_t          op,
  input  logic [olee_pkg::DATA_W-1:0] load_data,
  input  logic [olee_pkg::DATA_W-1:0] left_data,
  input  logic [olee_pkg::DATA_W-1:0] right_data,
  input  logic [olee_pkg::DATA_W-1:0] head_data,
  output logic [olee_pkg::DATA_W-1:0] data
);
  import olee_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    unique case (op)
      CELL_HOLD:  data_nxt = data_r;
      CELL_LOAD:  data_nxt = load_data;
      CELL_LEFT:  data_nxt = left_data;
      CELL_RIGHT: data_nxt = right_data;
      CELL_WRAP:  data_nxt = head_data;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: hw/rtl/olee_checker.sv
// ----------------------------------------------------------------------------
// olee_checker
// port-level checks on the ordered list edit engine
// ----------------------------------------------------------------------------
`include "ordered_list_edit_engine_macros.svh"

module olee_checker #(
  parameter int DEPTH = olee_pkg::DEPTH_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [olee_pkg::CMD_W-1:0]          in_cmd,
  input logic                                out_valid,
  input logic [olee_pkg::STATUS_W-1:0]       out_status,
  input logic signed [olee_pkg::DATA_W-1:0]  out_element,
  input logic [olee_pkg::POS_W-1:0]          out_count,
  input logic                                out_last
);
  import olee_pkg::*;

  // single-result commands answer in the next cycle
  `OLEE_ASSERT_NEXT(a_quick_result, clk, rst_n,
    start && !busy && in_cmd != CMD_INS_KEY && in_cmd != CMD_READ, out_valid && out_last)

  // a read out keeps going until its last element
  `OLEE_ASSERT_NEXT(a_read_runs, clk, rst_n, out_valid && !out_last, out_valid)

  // error results are single and carry no element
  `OLEE_ASSERT_SAME(a_err_single, clk, rst_n,
    out_valid && out_status != ST_OK, out_last && out_element == '0)

  `OLEE_ASSERT_SAME(a_count_range, clk, rst_n,
    out_valid, out_count <= POS_W'(DEPTH))

endmodule

bind ordered_list_edit_engine olee_checker #(.DEPTH(DEPTH)) u_olee_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_cmd      (in_cmd),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_element (out_element),
  .out_count   (out_count),
  .out_last    (out_last)
);

FILE: tb/ordered_list_edit_engine_tb.sv
// ----------------------------------------------------------------------------
// ordered_list_edit_engine_tb
// drives list edit commands through the start/busy channel, with random gaps
// between transfers, and checks every strobed result against a shadow copy of
// the list kept in a small scoreboard class
// ----------------------------------------------------------------------------
module ordered_list_edit_engine_tb;
  import olee_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 450;
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         count;
    logic                     last;
  } list_result_t;

  class list_mirror;
    localparam int SLOTS = DEPTH_DEF;
    logic signed [DATA_W-1:0] shadow_list [SLOTS];
    int shadow_count;
    list_result_t pending[$];
    int errors;

    function new();
      shadow_count = 0;
      errors = 0;
    endfunction

    function void queue_result(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] el,
                               logic lst);
      list_result_t r;
      r.status = st;
      r.element = el;
      r.count = shadow_count[POS_W-1:0];
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void place_at(int at, logic signed [DATA_W-1:0] v);
      int i;
      for (i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[at] = v;
      shadow_count++;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] v,
                               logic signed [DATA_W-1:0] k, logic [POS_W-1:0] pos);
      logic [STATUS_W-1:0] st;
      int i;
      int hit;
      st = ST_OK;
      case (cmd)
        CMD_APPEND: begin
          if (shadow_count >= SLOTS) st = ST_FULL;
          else place_at(shadow_count, v);
        end
        CMD_PREPEND: begin
          if (shadow_count >= SLOTS) st = ST_FULL;
          else place_at(0, v);
        end
        CMD_INS_KEY: begin
          if (shadow_count == 0) begin
            st = ST_EMPTY;
          end else begin
            hit = -1;
            for (i = 0; i < shadow_count; i++)
              if (hit < 0 && shadow_list[i] == k) hit = i;
            if (hit < 0) st = ST_NOKEY;
            else if (shadow_count >= SLOTS) st = ST_FULL;
            else place_at(hit + 1, v);
          end
        end
        CMD_DEL_TL: begin
          if (shadow_count == 0) st = ST_EMPTY;
          else shadow_count--;
        end
        CMD_DEL_POS: begin
          if (shadow_count == 0) begin
            st = ST_EMPTY;
          end else if (pos == 0 || pos > shadow_count) begin
            st = ST_BADPOS;
          end else begin
            for (i = pos - 1; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
            shadow_count--;
          end
        end
        CMD_READ: begin
          if (shadow_count == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            for (i = 0; i < shadow_count; i++)
              queue_result(ST_OK, shadow_list[i], (i + 1 == shadow_count));
          end
          return;
        end
        default: ;
      endcase
      queue_result(st, '0, 1'b1);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.element !== want.element)
        report_mismatch("element", got.element, want.element);
      if (got.count !== want.count) report_mismatch("count", got.count, want.count);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_cmd;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] in_key;
  logic [POS_W-1:0]         in_position;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_element;
  logic [POS_W-1:0]         out_count;
  logic                     out_last;

  list_mirror mirror = new();
  int idle_cycles = 0;

  ordered_list_edit_engine #(.DEPTH(DEPTH)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .in_key      (in_key),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_element (out_element),
    .out_count   (out_count),
    .out_last    (out_last)
  );

  always #10 clk = ~clk;

  // result side
  always @(posedge clk) begin
    list_result_t r;
    if (rst_n && out_valid) begin
      r.status = out_status;
      r.element = out_element;
      r.count = out_count;
      r.last = out_last;
      mirror.check_result(r);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] v,
                    logic signed [DATA_W-1:0] k, logic [POS_W-1:0] pos);
    int gap;
    gap = $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_value <= v;
    in_key <= k;
    in_position <= pos;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    mirror.note_command(cmd, v, k, pos);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $signed($urandom_range(0, 7)) - 4;
    return $urandom;
  endfunction

  initial begin
    int n;
    int insert_bias;
    int sel;
    logic [CMD_W-1:0] cmd;
    logic signed [DATA_W-1:0] k;
    logic [POS_W-1:0] pos;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_APPEND;
    in_value <= '0;
    in_key <= '0;
    in_position <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list cases
    send_command(CMD_READ, 0, 0, 1);
    send_command(CMD_DEL_TL, 0, 0, 1);
    send_command(CMD_DEL_POS, 0, 0, 1);
    send_command(CMD_INS_KEY, 1, 0, 1);
    // extremes and key search
    send_command(CMD_APPEND, 32'sh8000_0000, 0, 1);
    send_command(CMD_PREPEND, 32'sh7fff_ffff, 0, 1);
    send_command(CMD_INS_KEY, -1, 32'sh8000_0000, 1);
    send_command(CMD_INS_KEY, 5, 12345, 1);
    send_command(CMD_READ, 0, 0, 0);
    // bad positions, one valid delete, a read out and the spare commands
    send_command(CMD_DEL_POS, 0, 0, 0);
    send_command(CMD_DEL_POS, 0, 0, 7'h7f);
    send_command(CMD_DEL_POS, 0, 0, 4);
    send_command(CMD_DEL_POS, 0, 0, 2);
    send_command(CMD_READ, 0, 0, 0);
    send_command(CMD_SPARE_A, 32'sh7fff_ffff, -1, 7'h7f);
    send_command(CMD_SPARE_B, -1, 32'sh7fff_ffff, 7'h7f);
    // lone element removal
    send_command(CMD_DEL_TL, 0, 0, 0);
    send_command(CMD_DEL_POS, 0, 0, 1);
    send_command(CMD_READ, 0, 0, 0);

    // random phases of sixty items, each with its own insert bias, lean toward filling or draining
    insert_bias = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) insert_bias = $urandom_range(15, 90);
      sel = $urandom_range(0, 99);
      if (sel < 10) cmd = CMD_READ;
      else if (sel < 13) cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      else if ($urandom_range(0, 99) < insert_bias) cmd = CMD_W'($urandom_range(0, 2));
      else cmd = $urandom_range(0, 1) ? CMD_DEL_TL : CMD_DEL_POS;

      if (mirror.shadow_count > 0 && $urandom_range(0, 3) != 0)
        k = mirror.shadow_list[$urandom_range(0, mirror.shadow_count - 1)];
      else
        k = pick_value();

      case ($urandom_range(0, 9))
        0: pos = '0;
        1: pos = POS_W'(mirror.shadow_count + 1);
        2: pos = POS_W'($urandom_range(0, 127));
        default: pos = (mirror.shadow_count > 0) ?
                       POS_W'($urandom_range(1, mirror.shadow_count)) : POS_W'(1);
      endcase

      send_command(cmd, pick_value(), k, pos);
    end
    start <= 1'b0;

    while (mirror.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mirror.pending.size() != 0)
      mirror.report_mismatch("results still outstanding", mirror.pending.size(), 0);

    if (mirror.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/olee_pkg.sv
hw/rtl/olee_cell.sv
hw/rtl/ordered_list_edit_engine.sv
hw/rtl/olee_checker.sv
tb/ordered_list_edit_engine_tb.sv
